### hdl/ordered_hash_map_engine_top_macros.svh
// ----------------------------------------------------------------------------
// ordered_hash_map_engine_top_macros
// Assertion macros for the ordered hash map engine.
// ----------------------------------------------------------------------------
`ifndef ORDERED_HASH_MAP_ENGINE_TOP_MACROS_SVH
`define ORDERED_HASH_MAP_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OHM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OHM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OHM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/ohm_pkg.sv
// ----------------------------------------------------------------------------
// ohm_pkg
// Shared types and constants of the ordered hash map engine.
// ----------------------------------------------------------------------------
package ohm_pkg;
  localparam int Capacity = 256;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = IdxW + 1;
  localparam logic [CntW-1:0] NilLink = CntW'(Capacity);

  typedef enum logic [1:0] {
    OP_GET = 2'd0, OP_SET = 2'd1, OP_DEL = 2'd2, OP_ITER = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_WALK, S_APPEND, S_ITER,
    S_CMP_RD, S_CMP_WR, S_HCLR, S_LINK_RD, S_LINK_WR, S_DONE
  } state_t;
endpackage

### hdl/ohm_if.sv
// ----------------------------------------------------------------------------
// ohm_in_if / ohm_out_if
// Valid/ready channels for operations and results.
// ----------------------------------------------------------------------------
interface ohm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key;
  logic [31:0] key_hash;
  logic [63:0] value_in;
  logic [8:0]  start_index;
  modport source (output valid, opcode, key, key_hash, value_in, start_index,
                  input ready);
  modport sink (input valid, opcode, key, key_hash, value_in, start_index,
                output ready);
endinterface

interface ohm_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  status;
  logic [63:0] key_out;
  logic [63:0] value_out;
  logic [8:0]  next_index;
  logic [8:0]  entries_live;
  logic [31:0] modification_count;
  modport source (output valid, found, status, key_out, value_out, next_index,
                  entries_live, modification_count, input ready);
  modport sink (input valid, found, status, key_out, value_out, next_index,
                entries_live, modification_count, output ready);
endinterface

### hdl/ordered_hash_map_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_hash_map_engine_top
// Insertion-ordered hash map over a 256-slot store in synchronous memories.
// ----------------------------------------------------------------------------
// One operation transaction is taken at a time and gives one result
// transaction. After reset the engine clears the bucket head memory before
// it accepts its first transaction. Memory reads are registered: a get, set
// or delete reads the bucket head and then walks the bucket chain one slot
// at a time; an iterate reads slots from the start index and skips dead
// slots; a set that triggers compaction moves the live slots down, clears
// the bucket heads and relinks the chains of the live slots. The result
// waits in an output register, and the next operation is not accepted until
// that register drains.
module ordered_hash_map_engine_top (
  input logic clk,
  input logic rst,
  ohm_in_if.sink   in_ch,
  ohm_out_if.source out_ch
);
`include "ordered_hash_map_engine_top_macros.svh"

  localparam int IW = ohm_pkg::IdxW;
  localparam int CW = ohm_pkg::CntW;

  // Slot memories: key, value, hash, link. Alive bits are flip-flops.
  logic [63:0] mem_key   [ohm_pkg::Capacity];
  logic [63:0] mem_val   [ohm_pkg::Capacity];
  logic [31:0] mem_hash  [ohm_pkg::Capacity];
  logic [CW-1:0] mem_link [ohm_pkg::Capacity];
  logic [CW-1:0] mem_head [ohm_pkg::Capacity];
  logic [ohm_pkg::Capacity-1:0] alive;

  ohm_pkg::state_t state, state_next;

  // Latched operation.
  ohm_pkg::opcode_t op;
  logic [63:0] key_r, val_r;
  logic [31:0] hash_r;

  logic [CW-1:0] used, live;
  logic [31:0] mods;
  logic [CW-1:0] idx, steps, wj;

  // Memory read ports (one address for slot memories, one for heads).
  logic [IW-1:0] s_raddr, h_raddr;
  logic [63:0] rd_key, rd_val;
  logic [31:0] rd_hash;
  logic [CW-1:0] rd_link, rd_head;

  // Write controls.
  logic s_we, kv_we, link_we, h_we;
  logic [IW-1:0] s_waddr, h_waddr;
  logic [63:0] w_key, w_val;
  logic [31:0] w_hash;
  logic [CW-1:0] w_link, w_head;

  // Output register.
  logic o_valid, o_found;
  logic [1:0] o_status;
  logic [63:0] o_key, o_val;
  logic [CW-1:0] o_next;

  always_ff @(posedge clk) begin
    if (s_we) begin
      mem_key[s_waddr]  <= w_key;
      mem_hash[s_waddr] <= w_hash;
    end
    if (kv_we) mem_val[s_waddr] <= w_val;
    if (link_we) mem_link[s_waddr] <= w_link;
    if (h_we) mem_head[h_waddr] <= w_head;
    rd_key  <= mem_key[s_raddr];
    rd_val  <= mem_val[s_raddr];
    rd_hash <= mem_hash[s_raddr];
    rd_link <= mem_link[s_raddr];
    rd_head <= mem_head[h_raddr];
  end

  logic [IW-1:0] bkt;
  assign bkt = hash_r[IW-1:0];

  logic hit;
  assign hit = (idx < used) && (steps < CW'(ohm_pkg::Capacity));
  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ohm_pkg::S_IDLE) && !o_valid;

  // Datapath register updates, computed combinationally.
  logic [CW-1:0] idx_next, steps_next, wj_next, used_next, live_next;
  logic [31:0] mods_next;
  logic done, d_found;
  logic [1:0] d_status;
  logic [63:0] d_key, d_val;
  logic [CW-1:0] d_next;
  logic alive_set, alive_clr;
  logic [IW-1:0] alive_addr;
  logic alive_trim;

  always_comb begin
    state_next = state;
    idx_next = idx; steps_next = steps; wj_next = wj;
    used_next = used; live_next = live; mods_next = mods;
    s_raddr = idx[IW-1:0]; h_raddr = bkt;
    s_we = 1'b0; kv_we = 1'b0; link_we = 1'b0; h_we = 1'b0;
    s_waddr = idx[IW-1:0]; h_waddr = bkt;
    w_key = key_r; w_val = val_r; w_hash = hash_r; w_link = rd_head;
    w_head = idx;
    done = 1'b0; d_found = 1'b0; d_status = ohm_pkg::ST_MISS;
    d_key = '0; d_val = '0; d_next = '0;
    alive_set = 1'b0; alive_clr = 1'b0; alive_addr = idx[IW-1:0];
    alive_trim = 1'b0;
    unique case (state)
      ohm_pkg::S_CLEAR: begin
        h_we = 1'b1; h_waddr = idx[IW-1:0]; w_head = ohm_pkg::NilLink;
        idx_next = idx + 1'b1;
        if (idx == CW'(ohm_pkg::Capacity - 1)) state_next = ohm_pkg::S_IDLE;
      end
      ohm_pkg::S_IDLE: begin
        h_raddr = in_ch.key_hash[IW-1:0];
        s_raddr = in_ch.start_index[IW-1:0];
        steps_next = '0;
        idx_next = in_ch.start_index;
        if (accept) begin
          if (ohm_pkg::opcode_t'(in_ch.opcode) == ohm_pkg::OP_ITER)
            state_next = ohm_pkg::S_ITER;
          else
            state_next = ohm_pkg::S_HEAD;
        end
      end
      ohm_pkg::S_HEAD: begin
        // Head read is ready; start the chain walk.
        idx_next = rd_head;
        s_raddr = rd_head[IW-1:0];
        if (live == '0) idx_next = ohm_pkg::NilLink;
        state_next = ohm_pkg::S_WALK;
      end
      ohm_pkg::S_WALK: begin
        if (hit && alive[idx[IW-1:0]] && rd_key == key_r) begin
          done = 1'b1;
          d_status = ohm_pkg::ST_OK;
          unique case (op)
            ohm_pkg::OP_GET: begin d_found = 1'b1; d_val = rd_val; end
            ohm_pkg::OP_SET: kv_we = 1'b1;
            default: begin
              d_found = 1'b1; alive_clr = 1'b1;
              live_next = live - 1'b1; mods_next = mods + 1'b1;
            end
          endcase
        end else if (hit) begin
          idx_next = rd_link; steps_next = steps + 1'b1;
          s_raddr = rd_link[IW-1:0];
        end else if (op == ohm_pkg::OP_SET) begin
          if (used < CW'(ohm_pkg::Capacity)) begin
            state_next = ohm_pkg::S_APPEND;
          end else if (live < CW'(ohm_pkg::Capacity)) begin
            idx_next = '0; wj_next = '0; s_raddr = '0;
            state_next = ohm_pkg::S_CMP_RD;
          end else begin
            done = 1'b1; d_status = ohm_pkg::ST_FULL;
          end
        end else begin
          done = 1'b1;
        end
      end
      ohm_pkg::S_APPEND: begin
        // rd_head still holds the head of this bucket.
        s_we = 1'b1; kv_we = 1'b1; link_we = 1'b1;
        s_waddr = used[IW-1:0]; w_link = rd_head;
        h_we = 1'b1; w_head = used;
        alive_set = 1'b1; alive_addr = used[IW-1:0];
        used_next = used + 1'b1; live_next = live + 1'b1;
        mods_next = mods + 1'b1;
        done = 1'b1; d_found = 1'b1; d_status = ohm_pkg::ST_OK;
      end
      ohm_pkg::S_ITER: begin
        if (idx < used) begin
          if (alive[idx[IW-1:0]]) begin
            done = 1'b1; d_found = 1'b1; d_status = ohm_pkg::ST_OK;
            d_key = rd_key; d_val = rd_val; d_next = idx + 1'b1;
          end else begin
            idx_next = idx + 1'b1; s_raddr = idx_next[IW-1:0];
          end
        end else begin
          done = 1'b1; d_next = ohm_pkg::NilLink;
        end
      end
      ohm_pkg::S_CMP_RD: begin
        // Data of slot idx is ready; move it down if alive.
        if (idx < used) begin
          if (alive[idx[IW-1:0]]) begin
            s_we = 1'b1; kv_we = 1'b1; s_waddr = wj[IW-1:0];
            w_key = rd_key; w_val = rd_val; w_hash = rd_hash;
            wj_next = wj + 1'b1;
          end
          idx_next = idx + 1'b1; s_raddr = idx_next[IW-1:0];
          state_next = ohm_pkg::S_CMP_WR;
        end else begin
          alive_trim = 1'b1;
          used_next = wj; live_next = wj; idx_next = '0;
          state_next = ohm_pkg::S_HCLR;
        end
      end
      ohm_pkg::S_CMP_WR: begin
        // One bubble so a read never meets its own write in flight.
        state_next = ohm_pkg::S_CMP_RD;
      end
      ohm_pkg::S_HCLR: begin
        h_we = 1'b1; h_waddr = idx[IW-1:0]; w_head = ohm_pkg::NilLink;
        idx_next = idx + 1'b1;
        if (idx == CW'(ohm_pkg::Capacity - 1)) begin
          idx_next = '0; s_raddr = '0;
          state_next = ohm_pkg::S_LINK_RD;
        end
      end
      ohm_pkg::S_LINK_RD: begin
        if (idx < used) begin
          h_raddr = rd_hash[IW-1:0];
          state_next = ohm_pkg::S_LINK_WR;
        end else begin
          h_raddr = bkt;
          state_next = ohm_pkg::S_DONE;
        end
      end
      ohm_pkg::S_LINK_WR: begin
        link_we = 1'b1; w_link = rd_head;
        h_we = 1'b1; h_waddr = rd_hash[IW-1:0]; w_head = idx;
        idx_next = idx + 1'b1; s_raddr = idx_next[IW-1:0];
        state_next = ohm_pkg::S_LINK_RD;
      end
      ohm_pkg::S_DONE: begin
        // Head of the new key's bucket is being read; append next.
        state_next = ohm_pkg::S_APPEND;
      end
      default: state_next = ohm_pkg::S_IDLE;
    endcase
    if (done) state_next = ohm_pkg::S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ohm_pkg::S_CLEAR;
      idx <= '0; steps <= '0; wj <= '0;
      used <= '0; live <= '0; mods <= '0;
      alive <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next; steps <= steps_next; wj <= wj_next;
      used <= used_next; live <= live_next; mods <= mods_next;
      if (alive_set) alive[alive_addr] <= 1'b1;
      if (alive_clr) alive[alive_addr] <= 1'b0;
      if (alive_trim) begin
        for (int i = 0; i < ohm_pkg::Capacity; i++)
          alive[i] <= (CW'(i) < wj);
      end
      if (done) o_valid <= 1'b1;
      else if (out_ch.ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= ohm_pkg::opcode_t'(in_ch.opcode);
      key_r <= in_ch.key; val_r <= in_ch.value_in;
      hash_r <= in_ch.key_hash;
    end
    if (done) begin
      o_found <= d_found; o_status <= d_status;
      o_key <= d_key; o_val <= d_val; o_next <= d_next;
    end
  end

  assign out_ch.valid = o_valid;
  assign out_ch.found = o_found;
  assign out_ch.status = o_status;
  assign out_ch.key_out = o_key;
  assign out_ch.value_out = o_val;
  assign out_ch.next_index = o_next;
  assign out_ch.entries_live = live;
  assign out_ch.modification_count = mods;

  `OHM_ASSERT_IMPL(a_live_le_used, clk, rst, 1'b1, live <= used)
  `OHM_ASSERT_IMPL(a_no_accept_busy, clk, rst, o_valid, !in_ch.ready)
  `OHM_ASSERT_NEXT(a_done_shows, clk, rst, done, o_valid)
endmodule

### test/ordered_hash_map_engine_top_tb.sv
// ----------------------------------------------------------------------------
// ordered_hash_map_engine_top_tb
// Self-checking bench for the insertion-ordered hash map engine.
// ----------------------------------------------------------------------------
// Operation transactions are driven at the falling edge and every accepted
// one is run through a behavioral map model kept in the bench. The model
// pushes its expected result into a queue. A monitor at the rising edge
// compares each result transaction field by field with the oldest entry.
// ----------------------------------------------------------------------------
module ordered_hash_map_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    ohm_pkg::status_t status;
    logic [63:0]      key_out;
    logic [63:0]      value_out;
    logic [8:0]       next_index;
    logic [8:0]       entries_live;
    logic [31:0]      modification_count;
  } map_result_t;

  logic clk;
  logic rst;
  ohm_in_if  in_ch ();
  ohm_out_if out_ch ();

  ordered_hash_map_engine_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Model of the map. Only slots below used_cnt are ever read.
  logic [8:0]  heads [ohm_pkg::Capacity];
  logic [63:0] m_key [ohm_pkg::Capacity];
  logic [63:0] m_val [ohm_pkg::Capacity];
  logic [31:0] m_hash [ohm_pkg::Capacity];
  logic [8:0]  m_link [ohm_pkg::Capacity];
  logic        m_alive [ohm_pkg::Capacity];
  int unsigned used_cnt, live_cnt;
  logic [31:0] mod_cnt;

  map_result_t pending_results[$];
  int   error_count;
  int   send_idle_pct, recv_stall_pct;
  logic sim_done;

  // Known keys, so that lookups and deletes often hit.
  logic [63:0] key_pool[$];
  logic [31:0] hash_pool[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int unsigned chain_lookup(input logic [63:0] k, input logic [31:0] h);
    int unsigned idx;
    int unsigned steps;
    idx = heads[h[7:0]];
    steps = 0;
    while (idx < used_cnt && idx < ohm_pkg::Capacity && steps < ohm_pkg::Capacity) begin
      if (m_alive[idx] && m_key[idx] == k) return idx;
      idx = m_link[idx];
      steps++;
    end
    return ohm_pkg::Capacity;
  endfunction

  function automatic void chain_insert(input int unsigned s);
    m_link[s] = heads[m_hash[s][7:0]];
    heads[m_hash[s][7:0]] = 9'(s);
  endfunction

  function automatic void compact_store();
    int unsigned j;
    j = 0;
    for (int unsigned i = 0; i < used_cnt; i++) begin
      if (m_alive[i]) begin
        m_key[j] = m_key[i];
        m_val[j] = m_val[i];
        m_hash[j] = m_hash[i];
        m_alive[j] = 1'b1;
        j++;
      end
    end
    for (int unsigned i = j; i < ohm_pkg::Capacity; i++) m_alive[i] = 1'b0;
    used_cnt = j;
    live_cnt = j;
    foreach (heads[i]) heads[i] = ohm_pkg::NilLink;
    for (int unsigned i = 0; i < j; i++) chain_insert(i);
  endfunction

  // Applies one operation to the model and queues the result it gives.
  function automatic void predict_map_op(input ohm_pkg::opcode_t op,
                                         input logic [63:0] k,
                                         input logic [31:0] h, input logic [63:0] v,
                                         input logic [8:0] start);
    map_result_t r;
    int unsigned s;
    r = '0;
    r.status = ohm_pkg::ST_MISS;
    s = (live_cnt == 0) ? ohm_pkg::Capacity : chain_lookup(k, h);
    case (op)
      ohm_pkg::OP_GET: begin
        if (s != ohm_pkg::Capacity) begin
          r.found = 1'b1; r.status = ohm_pkg::ST_OK; r.value_out = m_val[s];
        end
      end
      ohm_pkg::OP_SET: begin
        if (s != ohm_pkg::Capacity) begin
          m_val[s] = v;
          r.status = ohm_pkg::ST_OK;
        end else begin
          if (used_cnt >= ohm_pkg::Capacity && live_cnt < ohm_pkg::Capacity)
            compact_store();
          if (used_cnt >= ohm_pkg::Capacity) begin
            r.status = ohm_pkg::ST_FULL;
          end else begin
            s = used_cnt;
            m_key[s] = k; m_val[s] = v; m_hash[s] = h; m_alive[s] = 1'b1;
            chain_insert(s);
            used_cnt++; live_cnt++; mod_cnt++;
            r.found = 1'b1; r.status = ohm_pkg::ST_OK;
          end
        end
      end
      ohm_pkg::OP_DEL: begin
        if (s != ohm_pkg::Capacity) begin
          m_alive[s] = 1'b0;
          live_cnt--; mod_cnt++;
          r.found = 1'b1; r.status = ohm_pkg::ST_OK;
        end
      end
      default: begin
        r.next_index = ohm_pkg::NilLink;
        for (int unsigned i = start; i < used_cnt; i++) begin
          if (m_alive[i]) begin
            r.found = 1'b1; r.status = ohm_pkg::ST_OK;
            r.key_out = m_key[i]; r.value_out = m_val[i];
            r.next_index = 9'(i + 1);
            break;
          end
        end
      end
    endcase
    r.entries_live = 9'(live_cnt);
    r.modification_count = mod_cnt;
    pending_results.push_back(r);
  endfunction

  // Drives one operation and holds it until the engine takes it. Valid is
  // left high after the accepting edge; the next send replaces the operation,
  // or an idle cycle drops valid at the following falling edge.
  task automatic send_map_op(input ohm_pkg::opcode_t op, input logic [63:0] k,
                             input logic [31:0] h, input logic [63:0] v,
                             input logic [8:0] start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key <= k;
    in_ch.key_hash <= h;
    in_ch.value_in <= v;
    in_ch.start_index <= start;
    do @(posedge clk); while (!in_ch.ready);
    predict_map_op(op, k, h, v, start);
    @(negedge clk);
  endtask

  // The receiver stalls at random; its ready changes only at falling edges.
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    map_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_ch.status), 64'hx);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.found !== exp_r.found)
          report_mismatch("found", 64'(out_ch.found), 64'(exp_r.found));
        if (out_ch.status !== exp_r.status)
          report_mismatch("status", 64'(out_ch.status), 64'(exp_r.status));
        if (out_ch.key_out !== exp_r.key_out)
          report_mismatch("key_out", out_ch.key_out, exp_r.key_out);
        if (out_ch.value_out !== exp_r.value_out)
          report_mismatch("value_out", out_ch.value_out, exp_r.value_out);
        if (out_ch.next_index !== exp_r.next_index)
          report_mismatch("next_index", 64'(out_ch.next_index), 64'(exp_r.next_index));
        if (out_ch.entries_live !== exp_r.entries_live)
          report_mismatch("entries_live", 64'(out_ch.entries_live),
                          64'(exp_r.entries_live));
        if (out_ch.modification_count !== exp_r.modification_count)
          report_mismatch("modification_count", 64'(out_ch.modification_count),
                          64'(exp_r.modification_count));
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Hashes are kept to a few buckets now and then so that chains get long.
  function automatic logic [31:0] rand_hash();
    logic [31:0] h;
    h = $urandom();
    if ($urandom_range(2) == 0) h[7:0] = 8'($urandom_range(3));
    return h;
  endfunction

  task automatic insert_fresh_key();
    logic [63:0] k;
    logic [31:0] h;
    k = rand64();
    h = rand_hash();
    key_pool.push_back(k);
    hash_pool.push_back(h);
    send_map_op(ohm_pkg::OP_SET, k, h, rand64(), '0);
  endtask

  // Opcode, start and value bits are all random; keys mostly come from the pool.
  task automatic random_op(input int set_weight);
    int unsigned sel;
    int unsigned p;
    ohm_pkg::opcode_t op;
    sel = $urandom_range(99);
    if (sel < set_weight) op = ohm_pkg::OP_SET;
    else op = ohm_pkg::opcode_t'($urandom_range(3));
    if (op == ohm_pkg::OP_ITER) begin
      send_map_op(op, rand64(), $urandom(), rand64(),
                  ($urandom_range(9) == 0) ? 9'($urandom()) : 9'($urandom_range(256)));
    end else if (key_pool.size() != 0 && $urandom_range(9) < 8) begin
      p = $urandom_range(key_pool.size() - 1);
      send_map_op(op, key_pool[p], hash_pool[p], rand64(), 9'($urandom()));
    end else if (op == ohm_pkg::OP_SET) begin
      insert_fresh_key();
    end else begin
      send_map_op(op, rand64(), rand_hash(), rand64(), 9'($urandom()));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Edge cases on an empty and lightly filled map.
  task automatic test_directed();
    send_map_op(ohm_pkg::OP_GET, '0, '0, '0, '0);
    send_map_op(ohm_pkg::OP_DEL, '1, '1, '1, '1);
    send_map_op(ohm_pkg::OP_ITER, '0, '0, '0, '0);
    send_map_op(ohm_pkg::OP_SET, '1, '1, '1, '0);
    send_map_op(ohm_pkg::OP_SET, '0, '0, '0, '0);
    send_map_op(ohm_pkg::OP_SET, 64'h5, 32'h100, 64'hA5A5, '0); // shares bucket with key 0
    send_map_op(ohm_pkg::OP_SET, '1, '1, 64'h1234, '0);         // update in place
    send_map_op(ohm_pkg::OP_GET, '1, '1, '0, '0);
    send_map_op(ohm_pkg::OP_GET, 64'h5, 32'h100, '0, '0);
    send_map_op(ohm_pkg::OP_GET, 64'h6, 32'h100, '0, '0);       // miss on a busy chain
    send_map_op(ohm_pkg::OP_DEL, '0, '0, '0, '0);
    send_map_op(ohm_pkg::OP_DEL, '0, '0, '0, '0);               // already dead
    send_map_op(ohm_pkg::OP_ITER, '0, '0, '0, 9'd0);
    send_map_op(ohm_pkg::OP_ITER, '0, '0, '0, 9'd1);            // skips the dead slot
    send_map_op(ohm_pkg::OP_ITER, '0, '0, '0, 9'd3);
    send_map_op(ohm_pkg::OP_ITER, '0, '0, '0, 9'd256);
    send_map_op(ohm_pkg::OP_ITER, '0, '0, '0, 9'h1FF);
    send_map_op(ohm_pkg::OP_SET, '0, '0, '1, '0);               // reinsert after delete
    send_map_op(ohm_pkg::OP_ITER, '1, '1, '1, 9'd255);
  endtask

  // Fills the store to capacity, sends one more set, which gives the full status
  // or compacts, then frees and refills so that compaction runs.
  task automatic test_full_and_compact();
    while (used_cnt < ohm_pkg::Capacity) insert_fresh_key();
    wait_drained();
    send_map_op(ohm_pkg::OP_SET, rand64(), $urandom(), rand64(), '0);
    for (int i = 0; i < 40; i++) begin
      int unsigned p;
      p = $urandom_range(key_pool.size() - 1);
      send_map_op(ohm_pkg::OP_DEL, key_pool[p], hash_pool[p], '0, '0);
    end
    insert_fresh_key();
    for (int i = 0; i < 5; i++) random_op(30);
  endtask

  task automatic test_random(input int count, input int set_weight);
    for (int i = 0; i < count; i++) random_op(set_weight);
  endtask

  // Iterates through the whole map in order with well-formed cursors.
  task automatic test_full_iteration();
    logic [8:0] cursor;
    cursor = '0;
    while (cursor < used_cnt) begin
      send_map_op(ohm_pkg::OP_ITER, rand64(), $urandom(), rand64(), cursor);
      wait_drained();
      cursor = (used_cnt == 0) ? 9'(ohm_pkg::Capacity) : 9'(cursor + 1);
    end
  endtask

  initial begin
    sim_done = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.opcode = ohm_pkg::OP_GET;
    in_ch.key = '0;
    in_ch.key_hash = '0;
    in_ch.value_in = '0;
    in_ch.start_index = '0;
    out_ch.ready = 1'b0;
    foreach (heads[i]) begin
      heads[i] = ohm_pkg::NilLink;
      m_alive[i] = 1'b0;
      m_link[i] = '0;
    end
    used_cnt = 0;
    live_cnt = 0;
    mod_cnt = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    send_idle_pct = 51;
    test_random(80, 40);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    test_random(80, 40);
    test_full_iteration();
    send_idle_pct = 8;
    recv_stall_pct = 8;
    test_full_and_compact();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(60, 25);
    send_idle_pct = 8;
    recv_stall_pct = 8;
    test_random(60, 25);

    wait_drained();
    repeat (50) @(posedge clk);
    sim_done = 1'b1;
    if (error_count == 0) $display("ordered_hash_map_engine_top_tb OK");
    else $display("ordered_hash_map_engine_top_tb NOT OK");
    $finish;
  end

  // Run limit: far beyond the slowest legal run, compactions included.
  initial begin
    #8ms;
    if (!sim_done) begin
      $display("ordered_hash_map_engine_top_tb NOT OK");
      $finish;
    end
  end
endmodule

### files.f
+incdir+hdl
hdl/ohm_pkg.sv
hdl/ohm_if.sv
hdl/ordered_hash_map_engine_top.sv
test/ordered_hash_map_engine_top_tb.sv
